@@ hdl/amag_pkg.sv @@
// ----------------------------------------------------------------------------
// amag_pkg
// Shared types and codes for the multidimensional array address generator.
// ----------------------------------------------------------------------------
package amag_pkg;

  // Request codes as they arrive on the input channel
  typedef enum logic [1:0] {
    RT_HEADER = 2'd0,
    RT_BOUNDS = 2'd1,
    RT_INDEX  = 2'd2
  } req_type_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int ADDR_W  = 32;
  localparam int ESIZE_W = 16;
  localparam int NDIMS_W = 5;
  localparam int BOUND_W = 16;
  localparam int RANGE_W = 18;   // upper - lower + 1 spans -65534 .. 65536
  localparam int ID_IN_W = 4;
  localparam int DIM_IN_W = 4;

  // One classified item waiting between front and back
  typedef struct packed {
    req_type_t                 kind;
    logic [ID_IN_W-1:0]        id;
    logic [DIM_IN_W-1:0]       dim;
    logic [ADDR_W-1:0]         base;
    logic [ESIZE_W-1:0]        esize;
    logic [NDIMS_W-1:0]        ndims;
    logic [BOUND_W-1:0]        lower;
    logic [RANGE_W-1:0]        rng;
    logic [BOUND_W-1:0]        index;
  } q_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ESIZE_W-1:0] esize;
    logic [NDIMS_W-1:0] ndims;
  } desc_t;

  typedef struct packed {
    logic [BOUND_W-1:0] lower;
    logic [RANGE_W-1:0] rng;
  } dim_ent_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DESC,
    BK_MAC,
    BK_ADDR
  } bk_state_t;

endpackage

@@ hdl/amag_ifs.sv @@
// ----------------------------------------------------------------------------
// amag channel interfaces
// Valid/ready channels for request items and computed addresses.
// ----------------------------------------------------------------------------
interface amag_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         array_id;
  logic [3:0]         dim_pos;
  logic signed [31:0] base_address;
  logic [15:0]        element_size;
  logic [4:0]         num_dims;
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;
  logic signed [15:0] index_value;

  modport source (output valid, req_type, array_id, dim_pos, base_address,
                  element_size, num_dims, lower_bound, upper_bound, index_value,
                  input ready);
  modport sink   (input valid, req_type, array_id, dim_pos, base_address,
                  element_size, num_dims, lower_bound, upper_bound, index_value,
                  output ready);
endinterface

interface amag_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         query_array;
  logic signed [31:0] address;

  modport source (output valid, query_array, address, input ready);
  modport sink   (input valid, query_array, address, output ready);
endinterface

@@ hdl/amag_queue.sv @@
// ----------------------------------------------------------------------------
// amag_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module amag_queue
  import amag_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output q_entry_t q_data
);

  q_entry_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]      count_r, count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/amag_front.sv @@
// ----------------------------------------------------------------------------
// amag_front
// Accepts request items, drops the ones that do nothing, precomputes ranges.
// ----------------------------------------------------------------------------
module amag_front
  import amag_pkg::*;
#(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 16
) (
  amag_in_if.sink   in_chan,
  input  logic      q_full,
  output logic      push,
  output q_entry_t  push_data
);

  logic accept;
  logic id_ok;
  logic dim_ok;
  logic keep;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign id_ok  = {5'b0, in_chan.array_id} < 9'(MAX_ARRAYS);
  assign dim_ok = {2'b0, in_chan.dim_pos} < 6'(MAX_DIMS);

  // Drop unknown request codes, unknown arrays and bounds beyond the table
  always_comb begin
    unique case (req_type_t'(in_chan.req_type))
      RT_HEADER: keep = id_ok;
      RT_BOUNDS: keep = id_ok && dim_ok;
      RT_INDEX:  keep = id_ok;
      default:   keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    push_data.kind  = req_type_t'(in_chan.req_type);
    push_data.id    = in_chan.array_id;
    push_data.dim   = in_chan.dim_pos;
    push_data.base  = in_chan.base_address;
    push_data.esize = in_chan.element_size;
    push_data.ndims = in_chan.num_dims;
    push_data.lower = in_chan.lower_bound;
    push_data.rng   = {{(RANGE_W-BOUND_W){in_chan.upper_bound[BOUND_W-1]}},
                       in_chan.upper_bound}
                    - {{(RANGE_W-BOUND_W){in_chan.lower_bound[BOUND_W-1]}},
                       in_chan.lower_bound}
                    + RANGE_W'(1);
    push_data.index = in_chan.index_value;
  end

endmodule

@@ hdl/amag_back.sv @@
// ----------------------------------------------------------------------------
// amag_back
// Descriptor tables and the Horner accumulator that turns indices into
// addresses.
// ----------------------------------------------------------------------------
module amag_back
  import amag_pkg::*;
#(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_data,
  output logic      pop,
  amag_out_if.source out_chan
);

  localparam int ID_W    = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int SLOTS   = MAX_ARRAYS * MAX_DIMS;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  desc_t     desc_mem  [MAX_ARRAYS];
  dim_ent_t  dim_mem   [SLOTS];
  desc_t     desc_rd_r;
  dim_ent_t  dim_rd_r;

  bk_state_t state_r, state_nxt;

  logic [ID_IN_W-1:0]  cur_id_r;
  logic [BOUND_W-1:0]  cur_index_r;
  logic [NDIMS_W-1:0]  cnt_r;
  logic [NDIMS_W-1:0]  cnt_use_r;
  logic                last_r;
  logic [ADDR_W-1:0]   acc_r, acc_nxt;

  logic                out_valid_r;
  logic [ID_IN_W-1:0]  out_array_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_free;

  logic desc_we, dim_we, desc_re, dim_re, acc_ld, out_ld;

  logic [ID_W-1:0]     q_id;
  logic [SLOT_W-1:0]   wr_slot;
  logic [SLOT_W-1:0]   rd_slot;
  logic [NDIMS_W:0]    eff_dims;
  logic [NDIMS_W:0]    cnt_clamp;
  logic                last_nxt;

  logic [ADDR_W-1:0]   rng32;
  logic [ADDR_W-1:0]   diff32;
  logic [ADDR_W-1:0]   addr_calc;

  assign out_free = !out_valid_r || out_chan.ready;

  assign q_id    = ID_W'(q_data.id);
  assign wr_slot = SLOT_W'(int'(q_data.id) * MAX_DIMS + int'(q_data.dim));

  // Clamp the stored dimension count and the running count
  always_comb begin
    if (desc_rd_r.ndims == '0) begin
      eff_dims = (NDIMS_W+1)'(1);
    end else if ({1'b0, desc_rd_r.ndims} > (NDIMS_W+1)'(MAX_DIMS)) begin
      eff_dims = (NDIMS_W+1)'(MAX_DIMS);
    end else begin
      eff_dims = {1'b0, desc_rd_r.ndims};
    end
    cnt_clamp = ({1'b0, cnt_r} >= eff_dims) ? eff_dims - 1'b1 : {1'b0, cnt_r};
    last_nxt  = (cnt_clamp + 1'b1) >= eff_dims;
  end

  assign rd_slot = SLOT_W'(int'(cur_id_r) * MAX_DIMS + int'(cnt_clamp));

  assign rng32  = {{(ADDR_W-RANGE_W){dim_rd_r.rng[RANGE_W-1]}}, dim_rd_r.rng};
  assign diff32 = {{(ADDR_W-BOUND_W){cur_index_r[BOUND_W-1]}}, cur_index_r}
                - {{(ADDR_W-BOUND_W){dim_rd_r.lower[BOUND_W-1]}}, dim_rd_r.lower};
  assign acc_nxt   = acc_r * rng32 + diff32;
  assign addr_calc = desc_rd_r.base + acc_r * {{(ADDR_W-ESIZE_W){1'b0}}, desc_rd_r.esize};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && q_data.kind == RT_INDEX) begin
          state_nxt = BK_DESC;
        end
      end
      BK_DESC: state_nxt = BK_MAC;
      BK_MAC:  state_nxt = last_r ? BK_ADDR : BK_IDLE;
      BK_ADDR: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop     = 1'b0;
    desc_we = 1'b0;
    dim_we  = 1'b0;
    desc_re = 1'b0;
    dim_re  = 1'b0;
    acc_ld  = 1'b0;
    out_ld  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_data.kind)
            RT_HEADER: desc_we = 1'b1;
            RT_BOUNDS: dim_we  = 1'b1;
            RT_INDEX:  desc_re = 1'b1;
            default:   pop     = 1'b1;
          endcase
        end
      end
      BK_DESC: dim_re = 1'b1;
      BK_MAC:  acc_ld = 1'b1;
      BK_ADDR: out_ld = out_free;
      default: pop    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_ld) begin
        acc_r <= acc_nxt;
        if (!last_r) begin
          cnt_r <= cnt_use_r + 1'b1;
        end
      end
      if (out_ld) begin
        acc_r <= '0;
        cnt_r <= '0;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Query context and result payload
  always_ff @(posedge clk) begin
    if (desc_re) begin
      cur_id_r    <= q_data.id;
      cur_index_r <= q_data.index;
    end
    if (dim_re) begin
      cnt_use_r <= NDIMS_W'(cnt_clamp);
      last_r    <= last_nxt;
    end
    if (out_ld) begin
      out_array_r <= cur_id_r;
      out_addr_r  <= addr_calc;
    end
  end

  // Descriptor table
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[q_id] <= '{base: q_data.base, esize: q_data.esize, ndims: q_data.ndims};
    end
    if (desc_re) begin
      desc_rd_r <= desc_mem[q_id];
    end
  end

  // Per-dimension table
  always_ff @(posedge clk) begin
    if (dim_we) begin
      dim_mem[wr_slot] <= '{lower: q_data.lower, rng: q_data.rng};
    end
    if (dim_re) begin
      dim_rd_r <= dim_mem[rd_slot];
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.query_array = out_array_r;
  assign out_chan.address     = out_addr_r;

endmodule

@@ hdl/multidim_array_address_gen_top.sv @@
// ----------------------------------------------------------------------------
// multidim_array_address_gen_top
// Row-major address generator over a table of array descriptors.
//
// in_chan carries header, bounds and index items (valid/ready); a transfer
// happens when both are high. Header and bounds items write the descriptor
// tables and produce nothing. Index items supply one index each to a
// query, first dimension first; the last one yields one out_chan transfer
// with the array id and base + offset * element_size, modulo 2^32.
// The back end handles a header or bounds item in its idle state. An index
// item passes through a descriptor read, a dimension read and a
// multiply-accumulate; the last index of a query also passes through a final
// multiply-add into the output register. The back end takes no new item
// until it is back in its idle state.
// A two-entry queue decouples the input from the back end, and the output
// register holds a result while out_chan.ready is low; the back end then
// stalls and the queue fills before in_chan.ready drops.
// Reset clears the accumulator, the dimension count and the queue; table
// contents stay undefined until written.
// ----------------------------------------------------------------------------
module multidim_array_address_gen_top
  import amag_pkg::*;
#(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  amag_in_if.sink     in_chan,
  amag_out_if.source  out_chan
);

  logic     push;
  q_entry_t push_data;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  q_entry_t q_data;

  amag_front #(
    .MAX_ARRAYS (MAX_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  amag_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  amag_back #(
    .MAX_ARRAYS (MAX_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the row-major array address generator. A directed
// table covers bound extremes, dimension-count clamping, reversed bounds,
// interleaved queries and descriptor rewrites mid-query. Random descriptor
// definitions and queries follow. Each result is checked against the in-bench
// predictor or a directed row's given result; both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import amag_pkg::*;

  localparam int MAX_ARRAYS   = 16;
  localparam int MAX_DIMS     = 16;
  localparam int IDLE_MAX     = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 15;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 500;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  id;
    logic [3:0]  dim;
    logic [31:0] base;
    logic [15:0] esize;
    logic [4:0]  ndims;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] idx;
  } amag_item_t;

  localparam int ITEM_W = $bits(amag_item_t);

  typedef struct packed {
    logic [3:0]  qarray;
    logic [31:0] addr;
  } addr_res_t;

  typedef struct packed {
    amag_item_t it;
    logic       typed;
    addr_res_t  res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  amag_in_if  in_chan ();
  amag_out_if out_chan ();

  multidim_array_address_gen_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state
  logic [31:0] base_tab   [MAX_ARRAYS];
  logic [15:0] esize_tab  [MAX_ARRAYS];
  logic [4:0]  ndims_tab  [MAX_ARRAYS];
  logic [31:0] lower_tab  [MAX_ARRAYS][MAX_DIMS];
  logic [31:0] range_tab  [MAX_ARRAYS][MAX_DIMS];
  bit          hdr_seen   [MAX_ARRAYS];
  bit          dim_seen   [MAX_ARRAYS][MAX_DIMS];
  logic [31:0] offset_acc;
  logic [4:0]  qcount;

  addr_res_t pending_addresses[$];
  dir_row_t  directed_rows[$];

  int unsigned mismatch_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cycle_cnt;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic int unsigned eff_dims_of(input logic [4:0] nd);
    if (nd == 5'd0) return 1;
    if (nd > MAX_DIMS) return MAX_DIMS;
    return 32'(nd);
  endfunction

  function automatic amag_item_t hdr_item(input logic [3:0] id, input logic [31:0] base,
                                          input logic [15:0] esize, input logic [4:0] nd);
    amag_item_t it;
    it       = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.req   = RT_HEADER;
    it.id    = id;
    it.base  = base;
    it.esize = esize;
    it.ndims = nd;
    return it;
  endfunction

  function automatic amag_item_t bnd_item(input logic [3:0] id, input logic [3:0] d,
                                          input logic [15:0] lo, input logic [15:0] hi);
    amag_item_t it;
    it     = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.req = RT_BOUNDS;
    it.id  = id;
    it.dim = d;
    it.lo  = lo;
    it.hi  = hi;
    return it;
  endfunction

  function automatic amag_item_t idx_item(input logic [3:0] id, input logic [15:0] v);
    amag_item_t it;
    it     = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.req = RT_INDEX;
    it.id  = id;
    it.idx = v;
    return it;
  endfunction

  function automatic amag_item_t rand_bounds(input logic [3:0] id, input logic [3:0] d);
    int unsigned        pick;
    logic signed [15:0] a;
    logic signed [15:0] b;
    pick = $urandom_range(0, 9);
    a    = 16'($urandom);
    b    = 16'($urandom);
    if (pick < 5) begin
      a = 16'($urandom_range(0, 100)) - 16'sd50;
      b = a + 16'($urandom_range(0, 7));
    end else if (pick < 8 && a > b) begin
      a = b;
      b = 16'($urandom);
      if (a > b) a = b - 16'sd1;
    end
    return bnd_item(id, d, a, b);
  endfunction

  task automatic predict_address(input amag_item_t it, output bit done, output addr_res_t res);
    int unsigned dims;
    int unsigned cnt;
    logic [31:0] lo32;
    logic [31:0] hi32;
    done = 1'b0;
    res  = '0;
    case (it.req)
      RT_HEADER: begin
        base_tab[it.id]  = it.base;
        esize_tab[it.id] = it.esize;
        ndims_tab[it.id] = it.ndims;
        hdr_seen[it.id]  = 1'b1;
      end
      RT_BOUNDS: begin
        lo32 = {{16{it.lo[15]}}, it.lo};
        hi32 = {{16{it.hi[15]}}, it.hi};
        lower_tab[it.id][it.dim] = lo32;
        range_tab[it.id][it.dim] = hi32 - lo32 + 32'd1;
        dim_seen[it.id][it.dim]  = 1'b1;
      end
      RT_INDEX: begin
        dims = eff_dims_of(ndims_tab[it.id]);
        cnt  = 32'(qcount);
        if (cnt >= dims) cnt = dims - 1;
        offset_acc = offset_acc * range_tab[it.id][cnt]
                   + ({{16{it.idx[15]}}, it.idx} - lower_tab[it.id][cnt]);
        if (cnt + 1 >= dims) begin
          done       = 1'b1;
          res.qarray = it.id;
          res.addr   = base_tab[it.id] + offset_acc * {16'd0, esize_tab[it.id]};
          offset_acc = '0;
          qcount     = '0;
        end else begin
          qcount = 5'(cnt + 1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input amag_item_t it, input bit typed, input addr_res_t typed_res);
    int unsigned gap;
    bit          done;
    addr_res_t   res;
    if (it.req != REQ_UNUSED) begin
      if (items_sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      items_sent++;
    end
    gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.req_type     <= it.req;
    in_chan.array_id     <= it.id;
    in_chan.dim_pos      <= it.dim;
    in_chan.base_address <= it.base;
    in_chan.element_size <= it.esize;
    in_chan.num_dims     <= it.ndims;
    in_chan.lower_bound  <= it.lo;
    in_chan.upper_bound  <= it.hi;
    in_chan.index_value  <= it.idx;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predict_address(it, done, res);
    if (done) pending_addresses.push_back(typed ? typed_res : res);
  endtask

  // Index item that only touches descriptor entries already written
  task automatic send_index(input logic [3:0] id, input bit in_range);
    int unsigned dims;
    int unsigned cnt;
    logic [15:0] lo;
    logic [31:0] rng;
    logic [15:0] v;
    if (!hdr_seen[id])
      send_item(hdr_item(id, $urandom, 16'($urandom_range(1, 65535)),
                         5'($urandom_range(1, 4))), 1'b0, '0);
    dims = eff_dims_of(ndims_tab[id]);
    cnt  = 32'(qcount);
    if (cnt >= dims) cnt = dims - 1;
    if (!dim_seen[id][cnt]) send_item(rand_bounds(id, 4'(cnt)), 1'b0, '0);
    lo  = lower_tab[id][cnt][15:0];
    rng = range_tab[id][cnt];
    if (in_range && rng >= 1 && rng <= 4096)
      v = lo + 16'($urandom_range(0, rng - 1));
    else
      v = 16'($urandom);
    send_item(idx_item(id, v), 1'b0, '0);
  endtask

  task automatic define_array(input logic [3:0] id);
    int unsigned pick;
    logic [4:0]  nd;
    logic [15:0] esize;
    pick  = $urandom_range(0, 19);
    nd    = 5'($urandom_range(1, 4));
    esize = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
    if (pick >= 19)      nd = 5'($urandom_range(17, 31));
    else if (pick >= 17) nd = 5'd0;
    else if (pick >= 14) nd = 5'($urandom_range(5, MAX_DIMS));
    send_item(hdr_item(id, $urandom, esize, nd), 1'b0, '0);
    for (int d = 0; d < eff_dims_of(nd); d++)
      send_item(rand_bounds(id, 4'(d)), 1'b0, '0);
  endtask

  task automatic run_query(input logic [3:0] id);
    int unsigned n;
    n = eff_dims_of(hdr_seen[id] ? ndims_tab[id] : 5'd1);
    for (int k = 0; k < n; k++) send_index(id, $urandom_range(0, 9) != 0);
  endtask

  // Result side: random stalls, one long hold-off, field checks
  initial begin
    int unsigned stall;
    bit          hold_done;
    addr_res_t   exp_res;
    hold_done      = 1'b0;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      results_seen++;
      if (pending_addresses.size() == 0) begin
        report_mismatch($sformatf("unexpected result array %0d address %h",
                                  out_chan.query_array, out_chan.address));
      end else begin
        exp_res = pending_addresses.pop_front();
        if (out_chan.query_array !== exp_res.qarray)
          report_mismatch($sformatf("query_array got %0d exp %0d",
                                    out_chan.query_array, exp_res.qarray));
        if (out_chan.address !== exp_res.addr)
          report_mismatch($sformatf("address got %h exp %h (array %0d)",
                                    out_chan.address, exp_res.addr, exp_res.qarray));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk) cycle_cnt++;
    $display("timeout after %0d cycles", cycle_cnt);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned pick;
    mismatch_cnt = 0;
    items_sent   = 0;
    results_seen = 0;
    no_idle      = 1'b0;
    offset_acc   = '0;
    qcount       = '0;
    for (int a = 0; a < MAX_ARRAYS; a++) begin
      hdr_seen[a] = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) dim_seen[a][d] = 1'b0;
    end

    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.req_type     <= RT_HEADER;
    in_chan.array_id     <= '0;
    in_chan.dim_pos      <= '0;
    in_chan.base_address <= '0;
    in_chan.element_size <= '0;
    in_chan.num_dims     <= '0;
    in_chan.lower_bound  <= '0;
    in_chan.upper_bound  <= '0;
    in_chan.index_value  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-dimension basics, then full-range bounds with a clamped count of zero
    directed_rows.push_back('{hdr_item(4'd0, 32'h0000_1000, 16'd4, 5'd1), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd0, 4'd0, 16'sd0, 16'sd9), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd0, 16'sd3), 1'b1, {4'd0, 32'h0000_100C}});
    directed_rows.push_back('{hdr_item(4'd1, 32'h8000_0000, 16'hFFFF, 5'd0), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd1, 4'd0, 16'sh8000, 16'sh7FFF), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd1, 16'sh7FFF), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd1, 16'sh8000), 1'b1, {4'd1, 32'h8000_0000}});
    // Two dimensions with reversed second bounds; a query on another array cuts in
    directed_rows.push_back('{hdr_item(4'd2, 32'h7FFF_FFFF, 16'd1, 5'd2), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd2, 4'd0, -16'sd5, 16'sd5), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd2, 4'd1, 16'sd10, 16'sd3), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd2, 16'sd0), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd1, 16'sd5), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd2, -16'sd5), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd2, 16'sd7), 1'b0, '0});
    directed_rows.push_back('{{REQ_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F,
                               16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    directed_rows.push_back('{hdr_item(4'd3, 32'h0000_0010, 16'd2, 5'd31), 1'b0, '0});
    // Bounds rewritten between the two indices of a query
    directed_rows.push_back('{hdr_item(4'd4, 32'h0000_4000, 16'd8, 5'd2), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd4, 4'd0, 16'sd0, 16'sd3), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd4, 4'd1, 16'sd0, 16'sd3), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd4, 16'sd1), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd4, 4'd1, -16'sd2, 16'sd2), 1'b0, '0});
    directed_rows.push_back('{idx_item(4'd4, 16'sd2), 1'b0, '0});
    directed_rows.push_back('{bnd_item(4'd5, 4'd15, 16'sh7FFF, 16'sh8000), 1'b0, '0});

    foreach (directed_rows[r])
      send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].res);

    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        define_array(4'($urandom));
        run_query(4'($urandom_range(0, 15)));
      end else if (pick < 65) begin
        run_query(4'($urandom));
      end else if (pick < 75) begin
        send_item({REQ_UNUSED, 4'($urandom), 4'($urandom), $urandom, 16'($urandom),
                   5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)}, 1'b0, '0);
      end else if (pick < 85) begin
        send_item(hdr_item(4'($urandom), $urandom, 16'($urandom), 5'($urandom)), 1'b0, '0);
      end else if (pick < 93) begin
        send_item(bnd_item(4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom)),
                  1'b0, '0);
      end else begin
        send_index(4'($urandom), 1'b1);
      end
    end
    in_chan.valid <= 1'b0;

    while (pending_addresses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/amag_pkg.sv
hdl/amag_ifs.sv
hdl/amag_queue.sv
hdl/amag_front.sv
hdl/amag_back.sv
hdl/multidim_array_address_gen_top.sv
dv/tb.sv
